// ----- src/ssdd_pkg.sv -----
// Shared types and constants for the selector switch debounce and decode block.
// Holds the age width, contact indexes, position codes and the result struct.
// No dependencies.
package ssdd_pkg;

    // Width of the per-contact saturating age counter
    localparam int AGE_BITS = 16;
    // Width of the debounce threshold register
    localparam int THR_BITS = 16;
    // Compare width wide enough for both age and threshold
    localparam int CMP_BITS = (AGE_BITS > THR_BITS) ? AGE_BITS : THR_BITS;

    localparam int NUM_CONTACTS = 4;
    localparam int CNT_BITS     = $clog2(NUM_CONTACTS + 1);

    // Contact lanes, in priority order
    localparam int C_PARK_NEUTRAL = 0;
    localparam int C_REVERSE      = 1;
    localparam int C_THIRD        = 2;
    localparam int C_ONE_TWO      = 3;

    localparam logic [THR_BITS-1:0] DEBOUNCE_RESET = THR_BITS'(50);

    typedef logic [AGE_BITS-1:0] age_t;
    typedef logic [THR_BITS-1:0] thr_t;

    typedef enum logic [2:0] {
        POS_UNKNOWN      = 3'd0,
        POS_PARK_NEUTRAL = 3'd1,
        POS_REVERSE      = 3'd2,
        POS_DRIVE        = 3'd3,
        POS_THIRD        = 3'd4,
        POS_ONE_TWO      = 3'd5
    } pos_t;

    // One result beat
    typedef struct packed {
        logic just_entered;
        pos_t position;
    } result_t;

endpackage

// ----- src/ssdd_lane.sv -----
// One contact lane: edge tracking, saturating age counter and stable-closed flag.
// Depends on ssdd_pkg for the age and threshold widths.
module ssdd_lane
    import ssdd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,        // an input beat is taken this cycle
    input  logic level,          // raw contact level, 0 closed
    input  thr_t debounce_ticks,
    output logic stable_next     // stable-closed flag after this beat
);

    localparam age_t AGE_MAX = {AGE_BITS{1'b1}};

    logic prev_level_reg;
    logic prev_level_next;
    age_t age_reg;
    age_t age_next;
    logic stable_reg;

    // Restart the age on a level change, otherwise count up and saturate
    always_comb
    begin
        prev_level_next = level;
        if (level != prev_level_reg)
        begin
            age_next = '0;
        end
        else if (age_reg != AGE_MAX)
        begin
            age_next = age_reg + age_t'(1);
        end
        else
        begin
            age_next = age_reg;
        end

        if (CMP_BITS'(age_next) >= CMP_BITS'(debounce_ticks))
        begin
            stable_next = ~level;
        end
        else
        begin
            stable_next = stable_reg;
        end
    end

    // Hold lane state until a beat arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            age_reg        <= '0;
            stable_reg     <= 1'b0;
        end
        else if (advance)
        begin
            prev_level_reg <= prev_level_next;
            age_reg        <= age_next;
            stable_reg     <= stable_next;
        end
    end

endmodule

// ----- src/ssdd_merge.sv -----
// Merge stage: decodes the lanes' stable flags into a position, flags entry,
// and queues results in an output register plus a skid register.
// Depends on ssdd_pkg for position codes and the result struct.
module ssdd_merge
    import ssdd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,       // an input beat is taken this cycle
    input  logic [NUM_CONTACTS-1:0] closed,     // stable-closed flags after the beat
    output logic                    space,      // room for another beat
    output logic                    out_valid,
    input  logic                    out_ready,
    output result_t                 out_data
);

    logic [CNT_BITS-1:0] closed_count;
    pos_t    pos_new;
    result_t res_new;
    pos_t    cur_pos_reg;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    // Count closed contacts and pick the position by priority
    always_comb
    begin
        closed_count = '0;
        for (int k = 0; k < NUM_CONTACTS; k++)
        begin
            closed_count = closed_count + CNT_BITS'(closed[k]);
        end

        if (closed_count > CNT_BITS'(1))
        begin
            pos_new = POS_UNKNOWN;
        end
        else if (closed[C_PARK_NEUTRAL])
        begin
            pos_new = POS_PARK_NEUTRAL;
        end
        else if (closed[C_REVERSE])
        begin
            pos_new = POS_REVERSE;
        end
        else if (closed[C_THIRD])
        begin
            pos_new = POS_THIRD;
        end
        else if (closed[C_ONE_TWO])
        begin
            pos_new = POS_ONE_TWO;
        end
        else
        begin
            pos_new = POS_DRIVE;
        end

        res_new.position     = pos_new;
        res_new.just_entered = (pos_new != cur_pos_reg) && (pos_new != POS_UNKNOWN);
    end

    // Track the current position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg <= POS_UNKNOWN;
        end
        else if (push)
        begin
            cur_pos_reg <= pos_new;
        end
    end

    // Advance the two-entry result queue
    always_comb
    begin
        pop             = out_valid_reg & out_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = res_new;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_new;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign space     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/selector_switch_debounce_decode.sv -----
// Selector switch debounce and decode, top level: four contact lanes, one merge stage.
// Each result beat is registered as its input beat is taken. Throughput: one beat per
// cycle while the skid register is empty; the merge stage's output plus skid register
// lets s_tready stay high while one result waits. Reset (async, active low) opens all
// contacts, clears ages and stable flags, sets position unknown and threshold to 50.
// Depends on ssdd_pkg, ssdd_lane and ssdd_merge.
module selector_switch_debounce_decode
    import ssdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] park_neutral_level, [1] reverse_level,
                                   // [2] third_level, [3] one_two_level, [7:4] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] position, [3] just_entered, [7:4] zero
    // Threshold register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // debounce_ticks
);

    thr_t                    debounce_ticks_reg;
    logic                    advance;
    logic [NUM_CONTACTS-1:0] stable_next;
    logic                    space;
    result_t                 res;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_valid)
        begin
            debounce_ticks_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = space;
    assign advance   = s_tvalid & space;

    // One lane per contact
    for (genvar k = 0; k < NUM_CONTACTS; k++)
    begin : g_lane
        ssdd_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .level          (s_tdata[k]),
            .debounce_ticks (debounce_ticks_reg),
            .stable_next    (stable_next[k])
        );
    end

    ssdd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .closed    (stable_next),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {4'b0000, res.just_entered, res.position};

endmodule

// ----- tb/sv/selector_switch_debounce_decode_test.sv -----
// Testbench for selector_switch_debounce_decode: drives contact-level beats, predicts
// debounced positions in a local model and checks every result beat in order.
// Depends on ssdd_pkg and the selector_switch_debounce_decode RTL.
module selector_switch_debounce_decode_test;
    import ssdd_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [0] park_neutral, [1] reverse, [2] third, [3] one_two
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [2:0] position, [3] just_entered, [7:4] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    // Contact levels waiting to be sent, one tick per entry, bit k is lane k
    logic [3:0]  pending_levels[$];
    // Predicted result beats, oldest first
    result_t     expected_positions[$];

    // Local copy of the debounce state
    logic [3:0]  last_level    = 4'hF;
    age_t        contact_age [NUM_CONTACTS] = '{default: '0};
    logic [3:0]  stable_closed = '0;
    pos_t        shown_pos     = POS_UNKNOWN;
    thr_t        debounce      = DEBOUNCE_RESET;

    bit          idle_on    = 1'b1;
    int          src_gap    = 0;
    int          sink_gap   = 0;
    int          fail_count = 0;

    selector_switch_debounce_decode uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Advance the debounce state by one tick and decode the position
    function automatic result_t step_selector(input logic [3:0] levels);
        int      closed_count;
        pos_t    next_pos;
        result_t res;
        closed_count = 0;
        for (int k = 0; k < NUM_CONTACTS; k++)
        begin
            if (levels[k] != last_level[k])
            begin
                contact_age[k] = '0;
                last_level[k]  = levels[k];
            end
            else if (contact_age[k] != '1)
            begin
                contact_age[k] = contact_age[k] + 1'b1;
            end
            if (contact_age[k] >= debounce)
                stable_closed[k] = !levels[k];
            closed_count += stable_closed[k];
        end
        // Two or more closed is ambiguous; otherwise first closed lane wins
        if (closed_count > 1)
            next_pos = POS_UNKNOWN;
        else if (stable_closed[C_PARK_NEUTRAL])
            next_pos = POS_PARK_NEUTRAL;
        else if (stable_closed[C_REVERSE])
            next_pos = POS_REVERSE;
        else if (stable_closed[C_THIRD])
            next_pos = POS_THIRD;
        else if (stable_closed[C_ONE_TWO])
            next_pos = POS_ONE_TWO;
        else
            next_pos = POS_DRIVE;
        res.position     = next_pos;
        res.just_entered = (next_pos != shown_pos) && (next_pos != POS_UNKNOWN);
        shown_pos        = next_pos;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        // Keep the log short on a broken design
        if (fail_count <= 30)
            $display("mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
    endtask

    // Send contact beats from the pending queue, with random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive_levels
        logic free;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  = 0;
        end
        else
        begin
            free = !s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_positions.push_back(step_selector(s_tdata[3:0]));
                free = 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    src_gap = $urandom_range(1, 7);
            end
            if (free)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_levels.size() != 0)
                begin
                    s_tdata  <= {4'b0000, pending_levels.pop_front()};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side in random bursts
    always @(posedge clk or negedge rst_n)
    begin : drive_ready
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            sink_gap = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_positions.size() == 0)
            begin
                report_mismatch("unexpected result beat", m_tdata, 0);
            end
            else
            begin
                want = expected_positions.pop_front();
                if (m_tdata[2:0] !== want.position)
                    report_mismatch("position", m_tdata[2:0], want.position);
                if (m_tdata[3] !== want.just_entered)
                    report_mismatch("just_entered", m_tdata[3], want.just_entered);
                if (m_tdata[7:4] !== 4'b0000)
                    report_mismatch("padding", m_tdata[7:4], 0);
            end
        end
    end

    // Hold until every beat is sent and every result has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_levels.size() != 0 || s_tvalid || expected_positions.size() != 0);
    endtask

    task automatic set_debounce(input thr_t value);
        wait_idle();
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        debounce = value;
        @(negedge clk);
    endtask

    task automatic push_level(input logic [3:0] levels, input int count);
        for (int i = 0; i < count; i++)
            pending_levels.push_back(levels);
    endtask

    // Queue selector moves: mostly clean holds around the threshold, some
    // contact bounce before the hold, some holds cut short, some random patterns
    task automatic load_moves(input int budget, input int thr);
        logic [3:0] pattern;
        int         pick;
        int         run;
        int         bounce;
        while (budget > 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                pattern = 4'hF & ~(4'b0001 << $urandom_range(0, 3));
            else if (pick < 8)
                pattern = 4'hF;
            else
                pattern = 4'($urandom);
            if ($urandom_range(0, 2) == 0)
            begin
                bounce = $urandom_range(1, 3);
                for (int b = 0; b < bounce; b++)
                    pending_levels.push_back(pattern ^ 4'($urandom_range(1, 15)));
                budget -= bounce;
            end
            if ($urandom_range(0, 4) == 0)
                run = $urandom_range(1, thr + 1);
            else
                run = thr + 1 + $urandom_range(0, 3);
            push_level(pattern, run);
            budget -= run;
        end
    endtask

    initial
    begin : stimulus
        thr_t thr;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First ticks at the reset threshold: open contacts decode as drive at once
        push_level(4'hF, 1);
        push_level(4'hE, 1);

        // Zero threshold: every position, repeats, ambiguous pairs, all closed
        set_debounce('0);
        push_level(4'hF, 1);
        push_level(4'hE, 1);
        push_level(4'hD, 1);
        push_level(4'hB, 1);
        push_level(4'h7, 2);
        push_level(4'h3, 1);
        push_level(4'h7, 1);
        push_level(4'h0, 1);
        push_level(4'hF, 1);
        push_level(4'h6, 1);
        push_level(4'hE, 1);
        push_level(4'hF, 1);

        // Short glitch must be filtered, then a clean hold takes effect
        set_debounce(16'd2);
        push_level(4'hD, 1);
        push_level(4'hF, 1);
        push_level(4'hD, 3);
        push_level(4'hF, 3);

        // Random moves over several thresholds, some phases without idling
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       thr = 16'd1;
                1:       thr = 16'd0;
                2:       thr = 16'd3;
                3:       thr = DEBOUNCE_RESET;
                4:       thr = 16'd2;
                5:       thr = thr_t'($urandom_range(0, 9));
                6:       thr = thr_t'($urandom_range(0, 20));
                default: thr = 16'd5;
            endcase
            set_debounce(thr);
            idle_on = (p % 3 != 2);
            load_moves((p == 3) ? 270 : 200, thr);
        end

        // Largest threshold: a short hold never reaches it, so the flags stay put
        idle_on = 1'b0;
        set_debounce('1);
        push_level(4'h7, 8);
        push_level(4'hF, 4);

        // Closing stretch with no idling on either side
        set_debounce(16'd1);
        load_moves(150, 1);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ssdd_pkg.sv
src/ssdd_lane.sv
src/ssdd_merge.sv
src/selector_switch_debounce_decode.sv
tb/sv/selector_switch_debounce_decode_test.sv
